@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned ENT_W    = PRI_W + PAY_W;
  localparam int unsigned IN_W     = REQ_W + PRI_W + PAY_W;
  localparam int unsigned OUT_W    = ST_W + PRI_W + PAY_W + CNT_W;
  localparam int unsigned IN_TW    = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TW   = ((OUT_W + 7) / 8) * 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP        = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK_PRI   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE_PRI = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

  // Compare mode of the shared scan unit
  typedef enum logic [1:0] {
    MODE_LE,
    MODE_EQ,
    MODE_ANY
  } scan_mode_e;

  // Verdict of the scan unit for one entry
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx_next;
  } scan_res_t;

endpackage

@@ hw/rtl/spq_mem.sv @@
// Entry store of the priority queue: one write port, one registered read port.
// Depends on spq_pkg.
module spq_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [spq_pkg::IDX_W-1:0] waddr_i,
  input  logic [spq_pkg::ENT_W-1:0] wdata_i,
  input  logic [spq_pkg::IDX_W-1:0] raddr_i,
  output logic [spq_pkg::ENT_W-1:0] rdata_o
);
  import spq_pkg::*;

  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/spq_scan.sv @@
// Shared compare unit: judges one stored entry against the search key and
// steps the scan index. Depends on spq_pkg.
module spq_scan (
  input  spq_pkg::scan_mode_e       mode_i,
  input  logic [spq_pkg::PRI_W-1:0] key_i,
  input  logic [spq_pkg::PRI_W-1:0] entry_pri_i,
  input  logic [spq_pkg::IDX_W-1:0] idx_i,
  input  logic [spq_pkg::CNT_W-1:0] fill_i,
  output spq_pkg::scan_res_t        res_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0] idx_inc;

  assign idx_inc = CNT_W'(idx_i) + CNT_W'(1);

  // Compare and step
  always_comb begin
    res_o.idx_next = idx_inc[IDX_W-1:0];
    res_o.last     = (idx_inc == fill_i);
    case (mode_i)
      MODE_LE:  res_o.hit = (entry_pri_i <= key_i);
      MODE_EQ:  res_o.hit = (entry_pri_i == key_i);
      MODE_ANY: res_o.hit = 1'b1;
      default:  res_o.hit = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/stable_priority_queue.sv @@
// Stable priority queue: sorted entry store, one compare unit, a sequencer.
// Each entry scanned passes a read and an evaluate state, each entry moved a
//   read and a write state, and a stored push adds an insert state; the
//   result then waits in the done state until the output register is free.
// Throughput: one request at a time; the next is taken in the cycle after the
//   result is loaded. Reset empties the queue at once; the store is not cleared.
module stable_priority_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] req_type, [10:3] priority_req, [42:11] payload, rest zero
  input  logic [spq_pkg::IN_TW-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] status, [9:2] out_priority, [41:10] out_payload, [46:42] count
  output logic [spq_pkg::OUT_TW-1:0] m_axis_tdata
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [PRI_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [ST_W-1:0]  rst_q, rst_d;
  logic [PRI_W-1:0] rpri_q, rpri_d;
  logic [PAY_W-1:0] rpay_q, rpay_d;
  logic             m_valid_q, m_valid_d;
  logic [ST_W-1:0]  ost_q, ost_d;
  logic [PRI_W-1:0] opri_q, opri_d;
  logic [PAY_W-1:0] opay_q, opay_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;
  scan_mode_e       mode;
  scan_res_t        scan;
  logic             shift_up;
  logic             removes;
  logic [IDX_W-1:0] ptr_dec;
  logic [IDX_W-1:0] ptr_inc;
  logic [CNT_W-1:0] ptr_inc2;
  logic             s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign shift_up = (req_q == REQ_PUSH);
  assign removes  = (req_q == REQ_POP) || (req_q == REQ_REMOVE_PRI);
  assign ptr_dec  = ptr_q - IDX_W'(1);
  assign ptr_inc  = ptr_q + IDX_W'(1);
  assign ptr_inc2 = CNT_W'(ptr_q) + CNT_W'(2);

  // Pick compare mode from the request
  always_comb begin
    case (req_q)
      REQ_PUSH:                      mode = MODE_LE;
      REQ_POP, REQ_PEEK:             mode = MODE_ANY;
      REQ_PEEK_PRI, REQ_REMOVE_PRI:  mode = MODE_EQ;
      default:                       mode = MODE_ANY;
    endcase
  end

  spq_scan u_scan (
    .mode_i      (mode),
    .key_i       (key_q),
    .entry_pri_i (mem_rdata[PRI_W-1:0]),
    .idx_i       (idx_q),
    .fill_i      (fill_q),
    .res_o       (scan)
  );

  // Store access per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = mem_rdata;
    mem_raddr = idx_q;
    case (state_q)
      S_SHIFT_RD: mem_raddr = shift_up ? ptr_dec : ptr_inc;
      S_SHIFT_WR: mem_we = 1'b1;
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = {pay_q, key_q};
      end
      default: mem_raddr = idx_q;
    endcase
  end

  spq_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    pay_d     = pay_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    rst_d     = rst_q;
    rpri_d    = rpri_q;
    rpay_d    = rpay_q;
    m_valid_d = m_valid_q;
    ost_d     = ost_q;
    opri_d    = opri_q;
    opay_d    = opay_q;
    ocnt_d    = ocnt_q;

    // Drop the result once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          req_d  = s_axis_tdata[REQ_W-1:0];
          key_d  = s_axis_tdata[REQ_W +: PRI_W];
          pay_d  = s_axis_tdata[REQ_W+PRI_W +: PAY_W];
          rst_d  = STAT_OK;
          rpri_d = '0;
          rpay_d = '0;
          idx_d  = '0;
          case (s_axis_tdata[REQ_W-1:0])
            REQ_PUSH: begin
              if (fill_q == CNT_W'(CAPACITY)) begin
                rst_d   = STAT_FULL;
                state_d = S_DONE;
              end else if (fill_q == '0) begin
                state_d = S_INSERT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            REQ_POP, REQ_PEEK, REQ_PEEK_PRI, REQ_REMOVE_PRI: begin
              if (fill_q == '0) begin
                rst_d   = STAT_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (shift_up) begin
          // Find the slot behind all entries of lower or equal priority
          if (scan.hit && scan.last) begin
            idx_d   = scan.idx_next;
            state_d = S_INSERT;
          end else if (scan.hit) begin
            idx_d   = scan.idx_next;
            state_d = S_SCAN_RD;
          end else begin
            ptr_d   = fill_q[IDX_W-1:0];
            state_d = S_SHIFT_RD;
          end
        end else if (scan.hit) begin
          rpri_d = mem_rdata[PRI_W-1:0];
          rpay_d = mem_rdata[ENT_W-1:PRI_W];
          ptr_d  = idx_q;
          if (!removes) begin
            state_d = S_DONE;
          end else if (scan.last) begin
            fill_d  = fill_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (scan.last) begin
          rst_d   = STAT_EMPTY;
          state_d = S_DONE;
        end else begin
          idx_d   = scan.idx_next;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (shift_up) begin
          // Move entries up one slot, from the tail down to the gap
          ptr_d   = ptr_dec;
          state_d = (ptr_dec > idx_q) ? S_SHIFT_RD : S_INSERT;
        end else begin
          // Close the gap, moving entries down one slot
          ptr_d = ptr_inc;
          if (ptr_inc2 < fill_q) begin
            state_d = S_SHIFT_RD;
          end else begin
            fill_d  = fill_q - CNT_W'(1);
            state_d = S_DONE;
          end
        end
      end
      S_INSERT: begin
        fill_d  = fill_q + CNT_W'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register when it is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          ost_d     = rst_q;
          opri_d    = rpri_q;
          opay_d    = rpay_q;
          ocnt_d    = fill_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= '0;
      key_q     <= '0;
      pay_q     <= '0;
      idx_q     <= '0;
      ptr_q     <= '0;
      fill_q    <= '0;
      rst_q     <= STAT_OK;
      rpri_q    <= '0;
      rpay_q    <= '0;
      m_valid_q <= 1'b0;
      ost_q     <= STAT_OK;
      opri_q    <= '0;
      opay_q    <= '0;
      ocnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      key_q     <= key_d;
      pay_q     <= pay_d;
      idx_q     <= idx_d;
      ptr_q     <= ptr_d;
      fill_q    <= fill_d;
      rst_q     <= rst_d;
      rpri_q    <= rpri_d;
      rpay_q    <= rpay_d;
      m_valid_q <= m_valid_d;
      ost_q     <= ost_d;
      opri_q    <= opri_d;
      opay_q    <= opay_d;
      ocnt_q    <= ocnt_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TW'({ocnt_q, opay_q, opri_q, ost_q});

  // Fill level never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill level above capacity");

  // Fill level moves only on insert or on the end of a removal
  a_fill_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fill_q) |-> ($past(state_q) == S_INSERT || $past(state_q) == S_SCAN_EV
                          || $past(state_q) == S_SHIFT_WR))
    else $error("fill level changed outside insert or removal");

  // A refused push reports a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && ost_q == STAT_FULL) |-> (ocnt_q == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // Empty or not-found results carry no entry
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && ost_q == STAT_EMPTY) |-> (opri_q == '0 && opay_q == '0))
    else $error("entry returned with empty status");

  // The store is written only while a request is in work
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SHIFT_WR || state_q == S_INSERT))
    else $error("store written outside shift or insert");

endmodule

@@ dv/stable_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for stable_priority_queue: mirrors the sorted store in a
// small class and checks every reply. Depends on spq_pkg and the block's RTL.
module testbench;
  import spq_pkg::*;

  localparam int unsigned ITEMS        = 1750;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 8;

  // Field offsets inside the request and reply words
  localparam int unsigned IN_PRI_LSB  = REQ_W;
  localparam int unsigned IN_PAY_LSB  = REQ_W + PRI_W;
  localparam int unsigned OUT_PRI_LSB = ST_W;
  localparam int unsigned OUT_PAY_LSB = ST_W + PRI_W;
  localparam int unsigned OUT_CNT_LSB = ST_W + PRI_W + PAY_W;

  // Push weights of the random episodes, out of a hundred
  localparam int unsigned FILL_WEIGHT  = 85;
  localparam int unsigned DRAIN_WEIGHT = 10;
  localparam int unsigned MIXED_WEIGHT = 45;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
    logic [CNT_W-1:0] count;
  } reply_t;

  // Mirror of the sorted store, plus the replies still owed by the block
  class queue_mirror;
    logic [PRI_W-1:0] held_pri [CAPACITY];
    logic [PAY_W-1:0] held_pay [CAPACITY];
    int unsigned      held;
    reply_t           expected_replies[$];
    int unsigned      errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Close the gap left by the entry at the given slot
    function void take_out(int unsigned slot);
      for (int unsigned k = slot; k + 1 < held; k++) begin
        held_pri[k] = held_pri[k + 1];
        held_pay[k] = held_pay[k + 1];
      end
      held--;
    endfunction

    // Apply one accepted request to the mirror and queue the reply it owes
    function void note_request(logic [IN_TW-1:0] word);
      logic [REQ_W-1:0] kind;
      logic [PRI_W-1:0] pri;
      logic [PAY_W-1:0] pay;
      reply_t           rep;
      int unsigned      slot;
      kind = word[REQ_W-1:0];
      pri  = word[IN_PRI_LSB +: PRI_W];
      pay  = word[IN_PAY_LSB +: PAY_W];
      rep  = '0;
      rep.status = STAT_OK;
      case (kind)
        REQ_PUSH: begin
          if (held >= CAPACITY) begin
            rep.status = STAT_FULL;
          end else begin
            // go behind every entry of lower or equal priority
            slot = 0;
            while (slot < held && held_pri[slot] <= pri) slot++;
            for (int unsigned k = held; k > slot; k--) begin
              held_pri[k] = held_pri[k - 1];
              held_pay[k] = held_pay[k - 1];
            end
            held_pri[slot] = pri;
            held_pay[slot] = pay;
            held++;
          end
        end
        REQ_POP, REQ_PEEK: begin
          if (held == 0) begin
            rep.status = STAT_EMPTY;
          end else begin
            rep.pri = held_pri[0];
            rep.pay = held_pay[0];
            if (kind == REQ_POP) take_out(0);
          end
        end
        REQ_PEEK_PRI, REQ_REMOVE_PRI: begin
          slot = 0;
          while (slot < held && held_pri[slot] != pri) slot++;
          if (slot == held) begin
            rep.status = STAT_EMPTY;
          end else begin
            rep.pri = held_pri[slot];
            rep.pay = held_pay[slot];
            if (kind == REQ_REMOVE_PRI) take_out(slot);
          end
        end
        default: ;
      endcase
      rep.count = held[CNT_W-1:0];
      expected_replies.push_back(rep);
    endfunction

    function void report(string field, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Compare one reply with the oldest one owed
    function void check_reply(logic [OUT_TW-1:0] word);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with no request pending, expected none, actual 0x%0h",
                 $time, word);
        return;
      end
      want = expected_replies.pop_front();
      report("status", PAY_W'(want.status), PAY_W'(word[ST_W-1:0]));
      report("out_priority", PAY_W'(want.pri), PAY_W'(word[OUT_PRI_LSB +: PRI_W]));
      report("out_payload", want.pay, word[OUT_PAY_LSB +: PAY_W]);
      report("count", PAY_W'(want.count), PAY_W'(word[OUT_CNT_LSB +: CNT_W]));
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;

  queue_mirror mirror;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles   = 0;
  bit          send_steady   = 1'b0;
  bit          recv_steady   = 1'b0;

  stable_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Idle stretch: mostly none or short, now and then long
  function automatic int unsigned idle_len(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [PRI_W-1:0] pri,
                              input logic [PAY_W-1:0] pay);
    int unsigned gap;
    gap = idle_len(send_steady);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TW - IN_W){1'b0}}, pay, pri, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Bias towards a few values so that equal priorities meet often
  function automatic logic [PRI_W-1:0] random_priority();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return PRI_W'($urandom_range(0, 3));
    if (r < 65) return '1;
    if (r < 70) return '0;
    return PRI_W'($urandom);
  endfunction

  task automatic random_request(input int unsigned push_weight);
    logic [REQ_W-1:0] kind;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
    int unsigned      r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      kind = REQ_REMOVE_PRI + REQ_W'($urandom_range(1, 3));
    end else if (r < 3 + push_weight) begin
      kind = REQ_PUSH;
    end else begin
      case ($urandom_range(0, 3))
        0:       kind = REQ_POP;
        1:       kind = REQ_PEEK;
        2:       kind = REQ_PEEK_PRI;
        default: kind = REQ_REMOVE_PRI;
      endcase
    end
    // searches mostly aim at a priority that is held
    if ((kind == REQ_PEEK_PRI || kind == REQ_REMOVE_PRI) && mirror.held != 0 &&
        $urandom_range(0, 9) < 7)
      pri = mirror.held_pri[$urandom_range(0, mirror.held - 1)];
    else
      pri = random_priority();
    r = $urandom_range(0, 99);
    if (r < 5)       pay = '0;
    else if (r < 10) pay = '1;
    else             pay = $urandom;
    send_request(kind, pri, pay);
  endtask

  // Sink side: bursts of ready broken by stalls
  initial begin
    int unsigned run;
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = idle_len(recv_steady);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Note requests and check replies as they are taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) mirror.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) mirror.check_reply(m_axis_tdata);
    end
  end

  // Abort when nothing moves for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no request or reply for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned weight;
    bit          first_episode;
    mirror = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: every read misses, unknown kinds leave it alone
    send_request(REQ_POP, '0, '0);
    send_request(REQ_PEEK, '0, '0);
    send_request(REQ_PEEK_PRI, '0, '0);
    send_request(REQ_REMOVE_PRI, '1, '0);
    send_request(REQ_REMOVE_PRI + REQ_W'(1), '0, '0);
    send_request(REQ_REMOVE_PRI + REQ_W'(2), '1, '1);
    // Extremes of priority and payload, then two of equal priority
    send_request(REQ_PUSH, '1, '1);
    send_request(REQ_PUSH, '0, '0);
    send_request(REQ_PUSH, PRI_W'(7), 32'h1234_5678);
    send_request(REQ_PUSH, PRI_W'(7), 32'h8765_4321);
    send_request(REQ_PEEK, '0, '0);
    // Oldest of a priority is found and removed first
    send_request(REQ_PEEK_PRI, PRI_W'(7), '0);
    send_request(REQ_REMOVE_PRI, PRI_W'(7), '0);
    send_request(REQ_PEEK_PRI, PRI_W'(7), '0);
    send_request(REQ_PEEK_PRI, PRI_W'(3), '0);
    send_request(REQ_REMOVE_PRI, PRI_W'(3), '0);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_PEEK, '0, '0);
    send_request(REQ_REMOVE_PRI + REQ_W'(3), '1, '1);
    send_request(REQ_POP, '0, '0);
    send_request(REQ_POP, '0, '0);

    // Random episodes: fill up, drain down, or mix
    first_episode = 1'b1;
    while (requests_sent < ITEMS) begin
      mode = first_episode ? 0 : $urandom_range(0, 2);
      len  = first_episode ? 40 : $urandom_range(10, 60);
      first_episode = 1'b0;
      case (mode)
        0:       weight = FILL_WEIGHT;
        1:       weight = DRAIN_WEIGHT;
        default: weight = MIXED_WEIGHT;
      endcase
      send_steady = ($urandom_range(0, 4) == 0);
      recv_steady = ($urandom_range(0, 4) == 0);
      for (int unsigned n = 0; n < len && requests_sent < ITEMS; n++)
        random_request(weight);
    end
    s_axis_tvalid <= 1'b0;
    send_steady   = 1'b0;
    recv_steady   = 1'b0;

    // Wait for every owed reply, then a little longer for strays
    while (mirror.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_mem.sv
hw/rtl/spq_scan.sv
hw/rtl/stable_priority_queue.sv
dv/stable_priority_queue_tb.sv
